/* rtl/dtd_pkg.sv */
`default_nettype none

package dtd_pkg;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int FOC_W     = 20;
  localparam int DEPTH_W   = 16;
  localparam int DISP_W    = 16;
  localparam int POINT_W   = 16;
  localparam int QUO_W     = 16;
  localparam int NUM_W     = 40;
  localparam int DEN_W     = 30;

  localparam int DISP_SCALE      = 16000;
  localparam int COORD_WIDTH_DEF = 12;

  localparam logic [CFG_W-1:0]   FOCAL_X_RST   = 20'd179200;
  localparam logic [CFG_W-1:0]   FOCAL_Y_RST   = 20'd179200;
  localparam logic [CFG_W-1:0]   CENTER_X_RST  = 20'd81920;
  localparam logic [CFG_W-1:0]   CENTER_Y_RST  = 20'd61440;
  localparam logic [CFG_W-1:0]   BASELINE_RST  = 20'd120000;
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd500;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd20000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_CENTER_X  = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_BASELINE  = 3'd4,
    CFG_MIN_DEPTH = 3'd5,
    CFG_MAX_DEPTH = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

/* rtl/dtd_div.sv */
`default_nettype none

module dtd_div import dtd_pkg::*; #(
  parameter int LANES  = 1,
  parameter int DIV_W  = 20,
  parameter int SIDE_W = 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [LANES-1:0][DIV_W-1:0]        in_rem_i,
  input  wire logic [LANES-1:0][QUO_W-1:0]        in_low_i,
  input  wire logic [LANES-1:0][DIV_W-1:0]        in_den_i,
  input  wire logic [SIDE_W-1:0]                  in_side_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [LANES-1:0][QUO_W-1:0]             out_quo_o,
  output logic [SIDE_W-1:0]                       out_side_o
);

  // One restoring step per stage: the quotient bits shift in where the
  // numerator's low bits shift out.
  logic [QUO_W-1:0]                v_q;
  logic [QUO_W:0]                  rdy;
  logic [LANES-1:0][DIV_W-1:0]     rem_q  [QUO_W];
  logic [LANES-1:0][DIV_W-1:0]     den_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]     sh_q   [QUO_W];
  logic [SIDE_W-1:0]               side_q [QUO_W];
  logic [LANES-1:0][DIV_W-1:0]     rem_d  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]     sh_d   [QUO_W];
  logic                            src_v    [QUO_W];
  logic [LANES-1:0][DIV_W-1:0]     src_rem  [QUO_W];
  logic [LANES-1:0][DIV_W-1:0]     src_den  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]     src_sh   [QUO_W];
  logic [SIDE_W-1:0]               src_side [QUO_W];

  always_comb begin
    rdy[QUO_W] = out_ready_i;
    for (int k = QUO_W - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    src_v[0]    = in_valid_i;
    src_rem[0]  = in_rem_i;
    src_den[0]  = in_den_i;
    src_sh[0]   = in_low_i;
    src_side[0] = in_side_i;
    for (int k = 1; k < QUO_W; k++) begin
      src_v[k]    = v_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_den[k]  = den_q[k-1];
      src_sh[k]   = sh_q[k-1];
      src_side[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    logic           ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t           = {src_rem[k][l], src_sh[k][l][QUO_W-1]};
        diff        = t - {1'b0, src_den[k][l]};
        ge          = (t >= {1'b0, src_den[k][l]});
        rem_d[k][l] = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
        sh_d[k][l]  = {src_sh[k][l][QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < QUO_W; k++) begin
        if (rdy[k]) begin
          v_q[k] <= src_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (rdy[k] && src_v[k]) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= src_den[k];
        sh_q[k]   <= sh_d[k];
        side_q[k] <= src_side[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QUO_W-1];
  assign out_quo_o   = sh_q[QUO_W-1];
  assign out_side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

/* rtl/dtd_depth.sv */
`default_nettype none

module dtd_depth import dtd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DISP_W-1:0] disparity_i,
  input  wire logic [COORD_WIDTH-1:0]   row_i,
  input  wire logic [COORD_WIDTH-1:0]   col_i,
  input  wire logic [CFG_W-1:0]         focal_x_i,
  input  wire logic [CFG_W-1:0]         baseline_i,
  input  wire logic [DEPTH_W-1:0]       min_depth_i,
  input  wire logic [DEPTH_W-1:0]       max_depth_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [DEPTH_W-1:0]            depth_o,
  output logic [COORD_WIDTH-1:0]        row_o,
  output logic [COORD_WIDTH-1:0]        col_o
);

  localparam int SIDE_W = 2 + 2 * COORD_WIDTH;

  logic                   v1_q;
  logic [NUM_W-1:0]       num1_q;
  logic [DEN_W-1:0]       den1_q;
  logic                   pos1_q;
  logic [COORD_WIDTH-1:0] row1_q;
  logic [COORD_WIDTH-1:0] col1_q;
  logic                   rdy1;
  logic                   pos;
  logic                   ovf;

  logic                   div_ready;
  logic                   div_valid;
  logic [0:0][QUO_W-1:0]  div_quo;
  logic [SIDE_W-1:0]      div_side;

  logic                   v3_q;
  logic [DEPTH_W-1:0]     z3_q;
  logic [COORD_WIDTH-1:0] row3_q;
  logic [COORD_WIDTH-1:0] col3_q;
  logic [DEPTH_W-1:0]     z3_d;
  logic                   rdy3;
  logic                   d_pos;
  logic                   d_ovf;

  assign pos  = !disparity_i[DISP_W-1] && (disparity_i != '0);
  assign rdy1 = !v1_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      num1_q <= NUM_W'(focal_x_i) * NUM_W'(baseline_i);
      den1_q <= DEN_W'(DISP_SCALE) * DEN_W'(disparity_i[DISP_W-2:0]);
      pos1_q <= pos;
      row1_q <= row_i;
      col1_q <= col_i;
    end
  end

  // A quotient that does not fit in 16 bits is above any maximum depth.
  assign ovf = (DEN_W'(num1_q[NUM_W-1:QUO_W]) >= den1_q);

  dtd_div #(
    .LANES  (1),
    .DIV_W  (DEN_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (div_ready),
    .in_rem_i    (DEN_W'(num1_q[NUM_W-1:QUO_W])),
    .in_low_i    (num1_q[QUO_W-1:0]),
    .in_den_i    (den1_q),
    .in_side_i   ({pos1_q, ovf, row1_q, col1_q}),
    .out_valid_o (div_valid),
    .out_ready_i (rdy3),
    .out_quo_o   (div_quo),
    .out_side_o  (div_side)
  );

  assign d_pos = div_side[SIDE_W-1];
  assign d_ovf = div_side[SIDE_W-2];
  assign z3_d  = (d_pos && !d_ovf && (div_quo[0] >= min_depth_i) &&
                  (div_quo[0] <= max_depth_i)) ? div_quo[0] : '0;
  assign rdy3  = !v3_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && div_valid) begin
      z3_q   <= z3_d;
      row3_q <= div_side[2*COORD_WIDTH-1:COORD_WIDTH];
      col3_q <= div_side[COORD_WIDTH-1:0];
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign depth_o     = z3_q;
  assign row_o       = row3_q;
  assign col_o       = col3_q;

endmodule

`default_nettype wire

/* rtl/dtd_project.sv */
`default_nettype none

module dtd_project import dtd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [DEPTH_W-1:0]     depth_i,
  input  wire logic [COORD_WIDTH-1:0] row_i,
  input  wire logic [COORD_WIDTH-1:0] col_i,
  input  wire logic [CFG_W-1:0]       focal_x_i,
  input  wire logic [CFG_W-1:0]       focal_y_i,
  input  wire logic [CFG_W-1:0]       center_x_i,
  input  wire logic [CFG_W-1:0]       center_y_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [DEPTH_W-1:0]          depth_o,
  output logic signed [POINT_W-1:0]   point_x_o,
  output logic signed [POINT_W-1:0]   point_y_o,
  output logic                        point_valid_o
);

  localparam int DIFF_W = ((COORD_WIDTH + 8 > FOC_W) ? COORD_WIDTH + 8 : FOC_W) + 1;
  localparam int PROD_W = DIFF_W + DEPTH_W + 1;
  localparam int HI_W   = PROD_W - QUO_W;
  localparam int SIDE_W = DEPTH_W + 6;

  function automatic logic [POINT_W-1:0] sat_coord(logic neg, logic ovf, logic zero,
                                                    logic [QUO_W-1:0] q);
    logic [POINT_W-1:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q[QUO_W-1]) ? {1'b0, {(POINT_W-1){1'b1}}} : q;
    end else begin
      r = (ovf || (q > {1'b1, {(QUO_W-1){1'b0}}})) ? {1'b1, {(POINT_W-1){1'b0}}}
                                                     : POINT_W'(16'd0 - q);
    end
    return r;
  endfunction

  logic                     va_q;
  logic signed [DIFF_W-1:0] dx_q;
  logic signed [DIFF_W-1:0] dy_q;
  logic [DEPTH_W-1:0]       za_q;
  logic                     rdya;

  logic                     vb_q;
  logic signed [PROD_W-1:0] px_q;
  logic signed [PROD_W-1:0] py_q;
  logic [DEPTH_W-1:0]       zb_q;
  logic                     rdyb;

  logic                     vc_q;
  logic [PROD_W-1:0]        magx_q;
  logic [PROD_W-1:0]        magy_q;
  logic                     negx_q;
  logic                     negy_q;
  logic [DEPTH_W-1:0]       zc_q;
  logic                     rdyc;

  logic [HI_W-1:0]          hix;
  logic [HI_W-1:0]          hiy;
  logic                     ovfx;
  logic                     ovfy;

  logic                     div_ready;
  logic                     div_valid;
  logic [1:0][QUO_W-1:0]    div_quo;
  logic [SIDE_W-1:0]        div_side;

  logic                     vo_q;
  logic [DEPTH_W-1:0]       zo_q;
  logic [POINT_W-1:0]       xo_q;
  logic [POINT_W-1:0]       yo_q;
  logic                     rdyo;

  assign rdya = !va_q || rdyb;
  assign rdyb = !vb_q || rdyc;
  assign rdyc = !vc_q || div_ready;
  assign rdyo = !vo_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdya) begin
        va_q <= in_valid_i;
      end
      if (rdyb) begin
        vb_q <= va_q;
      end
      if (rdyc) begin
        vc_q <= vb_q;
      end
      if (rdyo) begin
        vo_q <= div_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdya && in_valid_i) begin
      dx_q <= $signed({{(DIFF_W-COORD_WIDTH-8){1'b0}}, col_i, 8'h00}) -
              $signed({{(DIFF_W-FOC_W){1'b0}}, center_x_i});
      dy_q <= $signed({{(DIFF_W-COORD_WIDTH-8){1'b0}}, row_i, 8'h00}) -
              $signed({{(DIFF_W-FOC_W){1'b0}}, center_y_i});
      za_q <= depth_i;
    end
    if (rdyb && va_q) begin
      px_q <= dx_q * $signed({1'b0, za_q});
      py_q <= dy_q * $signed({1'b0, za_q});
      zb_q <= za_q;
    end
    if (rdyc && vb_q) begin
      negx_q <= px_q[PROD_W-1];
      negy_q <= py_q[PROD_W-1];
      magx_q <= px_q[PROD_W-1] ? unsigned'(-px_q) : unsigned'(px_q);
      magy_q <= py_q[PROD_W-1] ? unsigned'(-py_q) : unsigned'(py_q);
      zc_q   <= zb_q;
    end
    if (rdyo && div_valid) begin
      zo_q <= div_side[SIDE_W-1:6];
      xo_q <= sat_coord(div_side[5], div_side[4], div_side[3], div_quo[0]);
      yo_q <= sat_coord(div_side[2], div_side[1], div_side[0], div_quo[1]);
    end
  end

  // A zero focal length always overflows, which saturates to the sign unless the product is zero.
  assign hix  = magx_q[PROD_W-1:QUO_W];
  assign hiy  = magy_q[PROD_W-1:QUO_W];
  assign ovfx = (hix >= HI_W'(focal_x_i));
  assign ovfy = (hiy >= HI_W'(focal_y_i));

  dtd_div #(
    .LANES  (2),
    .DIV_W  (FOC_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_ready_o  (div_ready),
    .in_rem_i    ({hiy[FOC_W-1:0], hix[FOC_W-1:0]}),
    .in_low_i    ({magy_q[QUO_W-1:0], magx_q[QUO_W-1:0]}),
    .in_den_i    ({focal_y_i, focal_x_i}),
    .in_side_i   ({zc_q, negx_q, ovfx, (magx_q == '0), negy_q, ovfy, (magy_q == '0)}),
    .out_valid_o (div_valid),
    .out_ready_i (rdyo),
    .out_quo_o   (div_quo),
    .out_side_o  (div_side)
  );

  assign in_ready_o    = rdya;
  assign out_valid_o   = vo_q;
  assign depth_o       = zo_q;
  assign point_x_o     = signed'(xo_q);
  assign point_y_o     = signed'(yo_q);
  assign point_valid_o = (zo_q != '0);

endmodule

`default_nettype wire

/* rtl/disparity_to_depth_point.sv */
// Throughput: one beat per cycle; every stage holds its own valid bit, so a
// stall at the output fills the empty stages before the input is held.
// The depth and both coordinates come from 16-stage restoring dividers.
// Reset clears all valid bits and loads the register defaults at once.
`default_nettype none

module disparity_to_depth_point import dtd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DISP_W-1:0] disparity_i,
  input  wire logic [COORD_WIDTH-1:0]   pixel_row_i,
  input  wire logic [COORD_WIDTH-1:0]   pixel_column_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [DEPTH_W-1:0]            depth_mm_o,
  output logic signed [POINT_W-1:0]     point_x_mm_o,
  output logic signed [POINT_W-1:0]     point_y_mm_o,
  output logic                          point_valid_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i
);

  logic [CFG_W-1:0]       focal_x_q;
  logic [CFG_W-1:0]       focal_y_q;
  logic [CFG_W-1:0]       center_x_q;
  logic [CFG_W-1:0]       center_y_q;
  logic [CFG_W-1:0]       baseline_q;
  logic [DEPTH_W-1:0]     min_depth_q;
  logic [DEPTH_W-1:0]     max_depth_q;

  logic                   mid_valid;
  logic                   mid_ready;
  logic [DEPTH_W-1:0]     mid_depth;
  logic [COORD_WIDTH-1:0] mid_row;
  logic [COORD_WIDTH-1:0] mid_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= FOCAL_X_RST;
      focal_y_q   <= FOCAL_Y_RST;
      center_x_q  <= CENTER_X_RST;
      center_y_q  <= CENTER_Y_RST;
      baseline_q  <= BASELINE_RST;
      min_depth_q <= MIN_DEPTH_RST;
      max_depth_q <= MAX_DEPTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FOCAL_X:   focal_x_q   <= cfg_data_i;
        CFG_FOCAL_Y:   focal_y_q   <= cfg_data_i;
        CFG_CENTER_X:  center_x_q  <= cfg_data_i;
        CFG_CENTER_Y:  center_y_q  <= cfg_data_i;
        CFG_BASELINE:  baseline_q  <= cfg_data_i;
        CFG_MIN_DEPTH: min_depth_q <= cfg_data_i[DEPTH_W-1:0];
        CFG_MAX_DEPTH: max_depth_q <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  dtd_depth #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_depth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .disparity_i (disparity_i),
    .row_i       (pixel_row_i),
    .col_i       (pixel_column_i),
    .focal_x_i   (focal_x_q),
    .baseline_i  (baseline_q),
    .min_depth_i (min_depth_q),
    .max_depth_i (max_depth_q),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .depth_o     (mid_depth),
    .row_o       (mid_row),
    .col_o       (mid_col)
  );

  dtd_project #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_project (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (mid_valid),
    .in_ready_o    (mid_ready),
    .depth_i       (mid_depth),
    .row_i         (mid_row),
    .col_i         (mid_col),
    .focal_x_i     (focal_x_q),
    .focal_y_i     (focal_y_q),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .depth_o       (depth_mm_o),
    .point_x_o     (point_x_mm_o),
    .point_y_o     (point_y_mm_o),
    .point_valid_o (point_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |->
      depth_mm_o == '0 && point_x_mm_o == '0 && point_y_mm_o == '0)
    else $error("invalid point carries nonzero fields");

  a_valid_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> point_valid_o == (depth_mm_o != '0))
    else $error("point_valid disagrees with depth");

  a_hold_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held while the pipeline is not stalled at the output");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  import dtd_pkg::*;

  typedef struct packed {
    logic [DEPTH_W-1:0]        depth;
    logic signed [POINT_W-1:0] px;
    logic signed [POINT_W-1:0] py;
    logic                      pvalid;
  } point_t;

  // Holds the camera registers and the points still owed by the pipeline.
  class depth_scoreboard;
    logic [CFG_W-1:0] fx, fy, cx, cy, base;
    logic [DEPTH_W-1:0] zmin, zmax;
    point_t owed[$];
    int errors;

    function new();
      fx = FOCAL_X_RST; fy = FOCAL_Y_RST; cx = CENTER_X_RST; cy = CENTER_Y_RST;
      base = BASELINE_RST; zmin = MIN_DEPTH_RST; zmax = MAX_DEPTH_RST;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_FOCAL_X:   fx = v;
        CFG_FOCAL_Y:   fy = v;
        CFG_CENTER_X:  cx = v;
        CFG_CENTER_Y:  cy = v;
        CFG_BASELINE:  base = v;
        CFG_MIN_DEPTH: zmin = v[DEPTH_W-1:0];
        CFG_MAX_DEPTH: zmax = v[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [POINT_W-1:0] reproject(longint coord, longint ctr,
                                                  longint foc, longint z);
      longint num, q;
      num = (coord * 256 - ctr) * z;
      if (foc == 0) q = num > 0 ? 32767 : (num < 0 ? -32768 : 0);
      else begin
        q = num / foc;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      return q[POINT_W-1:0];
    endfunction

    function void note_pixel(logic signed [DISP_W-1:0] d, logic [11:0] r, logic [11:0] c);
      point_t p;
      longint q, z;
      p = '0;
      z = 0;
      if (d > 0) begin
        q = (longint'(fx) * longint'(base)) / (longint'(DISP_SCALE) * longint'(d));
        if (q >= zmin && q <= zmax) z = q;
      end
      if (z != 0) begin
        p.depth = z[DEPTH_W-1:0];
        p.px = reproject(longint'(c), longint'(cx), longint'(fx), z);
        p.py = reproject(longint'(r), longint'(cy), longint'(fy), z);
        p.pvalid = 1'b1;
      end
      owed.push_back(p);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat %p", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0, cfg_we_i = 0;
  logic signed [DISP_W-1:0] disparity_i = 0;
  logic [11:0] pixel_row_i = 0, pixel_column_i = 0;
  logic [CFG_IDX_W-1:0] cfg_index_i = 0;
  logic [CFG_W-1:0] cfg_data_i = 0;
  logic in_ready_o, out_valid_o, point_valid_o;
  logic [DEPTH_W-1:0] depth_mm_o;
  logic signed [POINT_W-1:0] point_x_mm_o, point_y_mm_o;
  int send_idle = 0, recv_idle = 0;
  depth_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  disparity_to_depth_point dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_point({depth_mm_o, point_x_mm_o, point_y_mm_o, point_valid_o});
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Valid stays up from one beat to the next unless the sender idles.
  task automatic send_pixel(logic signed [DISP_W-1:0] d, logic [11:0] r, logic [11:0] c);
    cfg_we_i <= 0;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; disparity_i <= d; pixel_row_i <= r; pixel_column_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(d, r, c);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    cfg_we_i <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_pixel();
    logic signed [DISP_W-1:0] d;
    case ($urandom_range(9))
      0: d = DISP_W'($urandom);
      1: d = -$signed({1'b0, 15'($urandom)});
      2: d = DISP_W'($urandom_range(1, 16));
      default: d = DISP_W'($urandom_range(8, 1200));
    endcase
    send_pixel(d, 12'($urandom), 12'($urandom));
  endtask

  task automatic random_config(bit extreme);
    write_reg(CFG_FOCAL_X, extreme ? ($urandom_range(1) ? 20'hFFFFF : 20'd0)
                                   : CFG_W'($urandom_range(50000, 400000)));
    write_reg(CFG_FOCAL_Y, extreme ? ($urandom_range(1) ? 20'hFFFFF : 20'd0)
                                   : CFG_W'($urandom_range(50000, 400000)));
    write_reg(CFG_CENTER_X, extreme ? 20'hFFFFF : CFG_W'($urandom_range(0, 1048575)));
    write_reg(CFG_CENTER_Y, extreme ? 20'd0 : CFG_W'($urandom_range(0, 1048575)));
    write_reg(CFG_BASELINE, extreme ? 20'hFFFFF : CFG_W'($urandom_range(20000, 600000)));
    write_reg(CFG_MIN_DEPTH, extreme ? 20'd0 : CFG_W'($urandom_range(0, 2000)));
    write_reg(CFG_MAX_DEPTH, extreme ? 20'hFFFF : CFG_W'($urandom_range(3000, 65535)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_pixel(16'sh7FFF, 12'hFFF, 12'hFFF);
    send_pixel(16'sh8000, 0, 0);
    send_pixel(0, 100, 100);
    send_pixel(1, 0, 0);
    send_pixel(84, 0, 12'hFFF);
    send_pixel(168, 12'hFFF, 0);
    send_pixel(20000, 240, 320);
    send_pixel(2688, 5, 7);
    drain();
    write_reg(CFG_MIN_DEPTH, 0);
    write_reg(CFG_MAX_DEPTH, 16'hFFFF);
    write_reg(CFG_FOCAL_Y, 0);
    send_pixel(16'sh7FFF, 0, 0);
    send_pixel(100, 0, 0);
    send_pixel(100, 240, 0);
    send_pixel(1, 12'hFFF, 12'hFFF);
    drain();
    write_reg(CFG_FOCAL_X, 0);
    write_reg(CFG_BASELINE, 20'hFFFFF);
    send_pixel(50, 1, 1);
    drain();
    write_reg(CFG_FOCAL_X, 20'hFFFFF);
    write_reg(CFG_MIN_DEPTH, 1000);
    write_reg(CFG_MAX_DEPTH, 10);
    write_reg(CFG_CENTER_X, 20'hFFFFF);
    write_reg(CFG_CENTER_Y, 20'hFFFFF);
    send_pixel(500, 9, 9);
    send_pixel(5000, 9, 9);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      send_idle = ph < 3 ? 29 : (ph < 6 ? 56 : 0);
      recv_idle = ph < 3 ? 56 : (ph < 6 ? 29 : 0);
      random_config(ph % 3 == 2);
      repeat (92) random_pixel();
      drain();
    end
    if (sb.errors == 0 && sb.owed.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
rtl/dtd_pkg.sv
rtl/dtd_div.sv
rtl/dtd_depth.sv
rtl/dtd_project.sv
rtl/disparity_to_depth_point.sv
tb/sv/tb_top.sv
